// ===== src/dtq_pkg.sv =====
// Package with the shared types and codes of the deadline timer queue.
`timescale 1ns / 1ps

package dtq_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_REM_READ,
        ST_REM_DONE,
        ST_TICK_START,
        ST_TICK_SCAN,
        ST_TICK_DRAIN,
        ST_TICK_EVAL,
        ST_FIRE,
        ST_OUT_END,
        ST_OUT_MORE
    } state_t;

    typedef enum logic [2:0] {
        OSEL_ADD_OK,
        OSEL_ADD_FULL,
        OSEL_REM,
        OSEL_PEND_MORE,
        OSEL_PEND_LAST,
        OSEL_BEST_LAST
    } out_sel_t;

    typedef struct packed {
        logic     capture;
        logic     tick_init;
        logic     idx_clr;
        logic     idx_inc;
        logic     add_write;
        logic     rd_rem;
        logic     scan_issue;
        logic     best_clr;
        logic     fire;
        logic     out_load;
        out_sel_t out_sel;
    } dtq_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic slot_free;
        logic pipe_busy;
        logic best_valid;
        logic pend_valid;
        logic cnt_last;
        logic out_taken;
    } dtq_status_t;

endpackage

// ===== src/dtq_if.sv =====
// Handshake interfaces for the request and response words of the timer queue.
`timescale 1ns / 1ps

interface dtq_in_if #(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [TIME_BITS-1:0] now_time;
    logic [31:0]          period;
    logic                 periodic;
    logic [7:0]           slot_number;
    logic [31:0]          user_tag;

    modport source (
        output valid, func, now_time, period, periodic, slot_number, user_tag,
        input  ready
    );
    modport sink (
        input  valid, func, now_time, period, periodic, slot_number, user_tag,
        output ready
    );
endinterface

interface dtq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [1:0]  status;
    logic [7:0]  timer_slot;
    logic [31:0] tag_out;
    logic        last_of_run;

    modport source (
        output valid, event_kind, status, timer_slot, tag_out, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, event_kind, status, timer_slot, tag_out, last_of_run,
        output ready
    );
endinterface

// ===== src/dtq_ctrl.sv =====
// Controller state machine that sequences adds, removes and tick scans.
`timescale 1ns / 1ps

module dtq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [1:0]          req_func,
    output logic                req_ready,
    output dtq_pkg::dtq_cmd_t   cmd,
    input  dtq_pkg::dtq_status_t stat
);

    dtq_pkg::state_t state_reg;
    dtq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_func)
                        dtq_pkg::FUNC_ADD:    state_next = dtq_pkg::ST_ADD_SCAN;
                        dtq_pkg::FUNC_REMOVE: state_next = dtq_pkg::ST_REM_READ;
                        dtq_pkg::FUNC_TICK:   state_next = dtq_pkg::ST_TICK_START;
                        default:              state_next = dtq_pkg::ST_IDLE;
                    endcase
                end
            end
            dtq_pkg::ST_ADD_SCAN:
            begin
                if (stat.slot_free || stat.idx_last)
                begin
                    state_next = dtq_pkg::ST_OUT_END;
                end
            end
            dtq_pkg::ST_REM_READ:   state_next = dtq_pkg::ST_REM_DONE;
            dtq_pkg::ST_REM_DONE:   state_next = dtq_pkg::ST_OUT_END;
            dtq_pkg::ST_TICK_START: state_next = dtq_pkg::ST_TICK_SCAN;
            dtq_pkg::ST_TICK_SCAN:
            begin
                if (stat.idx_last)
                begin
                    state_next = dtq_pkg::ST_TICK_DRAIN;
                end
            end
            dtq_pkg::ST_TICK_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = dtq_pkg::ST_TICK_EVAL;
                end
            end
            dtq_pkg::ST_TICK_EVAL:
            begin
                if (stat.best_valid && !stat.pend_valid)
                begin
                    state_next = dtq_pkg::ST_FIRE;
                end
                else if (stat.best_valid)
                begin
                    state_next = dtq_pkg::ST_OUT_MORE;
                end
                else if (stat.pend_valid)
                begin
                    state_next = dtq_pkg::ST_OUT_END;
                end
                else
                begin
                    state_next = dtq_pkg::ST_IDLE;
                end
            end
            dtq_pkg::ST_FIRE:
            begin
                state_next = stat.cnt_last ? dtq_pkg::ST_OUT_END : dtq_pkg::ST_TICK_START;
            end
            dtq_pkg::ST_OUT_END:
            begin
                if (stat.out_taken)
                begin
                    state_next = dtq_pkg::ST_IDLE;
                end
            end
            dtq_pkg::ST_OUT_MORE:
            begin
                if (stat.out_taken)
                begin
                    state_next = dtq_pkg::ST_FIRE;
                end
            end
            default: state_next = dtq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd = '0;
        cmd.out_sel = dtq_pkg::OSEL_ADD_OK;
        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture   = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    cmd.tick_init = (req_func == dtq_pkg::FUNC_TICK);
                end
            end
            dtq_pkg::ST_ADD_SCAN:
            begin
                if (stat.slot_free)
                begin
                    cmd.add_write = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = dtq_pkg::OSEL_ADD_OK;
                end
                else if (stat.idx_last)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = dtq_pkg::OSEL_ADD_FULL;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            dtq_pkg::ST_REM_READ:
            begin
                cmd.rd_rem = 1'b1;
            end
            dtq_pkg::ST_REM_DONE:
            begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = dtq_pkg::OSEL_REM;
            end
            dtq_pkg::ST_TICK_START:
            begin
                cmd.idx_clr  = 1'b1;
                cmd.best_clr = 1'b1;
            end
            dtq_pkg::ST_TICK_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                cmd.idx_inc    = 1'b1;
            end
            dtq_pkg::ST_TICK_EVAL:
            begin
                if (stat.pend_valid)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = stat.best_valid ? dtq_pkg::OSEL_PEND_MORE
                                                   : dtq_pkg::OSEL_PEND_LAST;
                end
            end
            dtq_pkg::ST_FIRE:
            begin
                cmd.fire = 1'b1;
                if (stat.cnt_last)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = dtq_pkg::OSEL_BEST_LAST;
                end
            end
            default:
            begin
                cmd.out_sel = dtq_pkg::OSEL_ADD_OK;
            end
        endcase
    end

endmodule

// ===== src/dtq_datapath.sv =====
// Datapath with the slot table, the scan pipeline, the best-candidate and response registers.
`timescale 1ns / 1ps

module dtq_datapath #(
    parameter int TIMER_SLOTS = 256,
    parameter int MAX_FIRE    = 64,
    parameter int TIME_BITS   = 48,
    parameter int TAG_BITS    = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtq_pkg::dtq_cmd_t    cmd,
    output dtq_pkg::dtq_status_t stat,
    input  logic [TIME_BITS-1:0] now_time,
    input  logic [31:0]          period,
    input  logic                 periodic,
    input  logic [7:0]           slot_number,
    input  logic [31:0]          user_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           event_kind,
    output logic [1:0]           status,
    output logic [7:0]           timer_slot,
    output logic [31:0]          tag_out,
    output logic                 last_of_run
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;
    localparam int CNT_W = $clog2(MAX_FIRE + 1);

    typedef struct packed {
        logic                 rep;
        logic [31:0]          per;
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] dl;
    } slot_word_t;

    slot_word_t mem [TIMER_SLOTS];
    slot_word_t rd_reg;

    logic [TIME_BITS-1:0] op_now_reg;
    logic [31:0]          op_per_reg;
    logic                 op_rep_reg;
    logic [7:0]           op_sn_reg;
    logic [TAG_BITS-1:0]  op_tag_reg;

    logic [IDX_W-1:0]       idx_reg;
    logic [TIMER_SLOTS-1:0] in_use_reg;

    logic             s1_v_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_v_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    slot_word_t       s2_word_reg;

    logic             best_v_reg;
    logic [IDX_W-1:0] best_idx_reg;
    slot_word_t       best_word_reg;

    logic                 first_reg;
    logic [TIME_BITS-1:0] last_dl_reg;
    logic [IDX_W-1:0]     last_idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pend_v_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [TAG_BITS-1:0]  pend_tag_reg;
    logic                 rem_ok_reg;

    logic        out_v_reg;
    logic [1:0]  out_kind_reg;
    logic [1:0]  out_stat_reg;
    logic [7:0]  out_slot_reg;
    logic [31:0] out_tag_reg;
    logic        out_last_reg;

    logic [CW-1:0]        sn_w;
    logic [IDX_W-1:0]     sn_idx;
    logic                 rem_ok;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [IDX_W-1:0]     mem_raddr;
    slot_word_t           mem_wdata;
    logic [TIME_BITS-1:0] rearm_sum;
    logic [TIME_BITS-1:0] rearm_dl;
    logic                 s1_due;
    logic                 s1_above;

    assign sn_w   = CW'(op_sn_reg);
    assign sn_idx = sn_w[IDX_W-1:0];
    assign rem_ok = (sn_w < CW'(TIMER_SLOTS)) && in_use_reg[sn_idx];

    assign rearm_sum = best_word_reg.dl + TIME_BITS'(best_word_reg.per);
    assign rearm_dl  = (rearm_sum <= op_now_reg) ? op_now_reg + TIME_BITS'(1) : rearm_sum;

    always_comb
    begin
        mem_we    = cmd.add_write || (cmd.fire && best_word_reg.rep);
        mem_waddr = cmd.fire ? best_idx_reg : idx_reg;
        mem_raddr = cmd.rd_rem ? sn_idx : idx_reg;
        if (cmd.fire)
        begin
            mem_wdata    = best_word_reg;
            mem_wdata.dl = rearm_dl;
        end
        else
        begin
            mem_wdata.rep = op_rep_reg;
            mem_wdata.per = op_per_reg;
            mem_wdata.tag = op_tag_reg;
            mem_wdata.dl  = op_now_reg + TIME_BITS'(op_per_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[mem_raddr];
    end

    assign s1_due   = rd_reg.dl <= op_now_reg;
    assign s1_above = first_reg || (rd_reg.dl > last_dl_reg)
                   || ((rd_reg.dl == last_dl_reg) && (s1_idx_reg > last_idx_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_now_reg <= now_time;
            op_per_reg <= period;
            op_rep_reg <= periodic;
            op_sn_reg  <= slot_number;
            op_tag_reg <= TAG_BITS'(user_tag);
        end
        s1_idx_reg  <= idx_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_word_reg <= rd_reg;
        if (s2_v_reg && (!best_v_reg || (s2_word_reg.dl < best_word_reg.dl)))
        begin
            best_idx_reg  <= s2_idx_reg;
            best_word_reg <= s2_word_reg;
        end
        if (cmd.fire)
        begin
            last_dl_reg  <= best_word_reg.dl;
            last_idx_reg <= best_idx_reg;
            pend_idx_reg <= best_idx_reg;
            pend_tag_reg <= best_word_reg.tag;
        end
        if (cmd.rd_rem)
        begin
            rem_ok_reg <= rem_ok;
        end
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                dtq_pkg::OSEL_ADD_OK:
                begin
                    out_kind_reg <= dtq_pkg::KIND_ADD;
                    out_stat_reg <= dtq_pkg::STAT_OK;
                    out_slot_reg <= 8'(idx_reg);
                    out_tag_reg  <= '0;
                    out_last_reg <= 1'b0;
                end
                dtq_pkg::OSEL_ADD_FULL:
                begin
                    out_kind_reg <= dtq_pkg::KIND_ADD;
                    out_stat_reg <= dtq_pkg::STAT_FULL;
                    out_slot_reg <= '0;
                    out_tag_reg  <= '0;
                    out_last_reg <= 1'b0;
                end
                dtq_pkg::OSEL_REM:
                begin
                    out_kind_reg <= dtq_pkg::KIND_REMOVE;
                    out_stat_reg <= rem_ok_reg ? dtq_pkg::STAT_OK : dtq_pkg::STAT_NOTFOUND;
                    out_slot_reg <= op_sn_reg;
                    out_tag_reg  <= rem_ok_reg ? 32'(rd_reg.tag) : 32'd0;
                    out_last_reg <= 1'b0;
                end
                dtq_pkg::OSEL_PEND_MORE,
                dtq_pkg::OSEL_PEND_LAST:
                begin
                    out_kind_reg <= dtq_pkg::KIND_EXPIRE;
                    out_stat_reg <= dtq_pkg::STAT_OK;
                    out_slot_reg <= 8'(pend_idx_reg);
                    out_tag_reg  <= 32'(pend_tag_reg);
                    out_last_reg <= (cmd.out_sel == dtq_pkg::OSEL_PEND_LAST);
                end
                dtq_pkg::OSEL_BEST_LAST:
                begin
                    out_kind_reg <= dtq_pkg::KIND_EXPIRE;
                    out_stat_reg <= dtq_pkg::STAT_OK;
                    out_slot_reg <= 8'(best_idx_reg);
                    out_tag_reg  <= 32'(best_word_reg.tag);
                    out_last_reg <= 1'b1;
                end
                default:
                begin
                    out_kind_reg <= dtq_pkg::KIND_ADD;
                    out_stat_reg <= dtq_pkg::STAT_OK;
                    out_slot_reg <= '0;
                    out_tag_reg  <= '0;
                    out_last_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            in_use_reg <= '0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            best_v_reg <= 1'b0;
            first_reg  <= 1'b1;
            cnt_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.add_write)
            begin
                in_use_reg[idx_reg] <= 1'b1;
            end
            if (cmd.rd_rem && rem_ok)
            begin
                in_use_reg[sn_idx] <= 1'b0;
            end
            if (cmd.fire && !best_word_reg.rep)
            begin
                in_use_reg[best_idx_reg] <= 1'b0;
            end
            s1_v_reg <= cmd.scan_issue;
            s2_v_reg <= s1_v_reg && in_use_reg[s1_idx_reg] && s1_due && s1_above;
            if (cmd.best_clr)
            begin
                best_v_reg <= 1'b0;
            end
            else if (s2_v_reg)
            begin
                best_v_reg <= 1'b1;
            end
            if (cmd.tick_init)
            begin
                first_reg  <= 1'b1;
                cnt_reg    <= '0;
                pend_v_reg <= 1'b0;
            end
            else if (cmd.fire)
            begin
                first_reg  <= 1'b0;
                cnt_reg    <= cnt_reg + CNT_W'(1);
                pend_v_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_v_reg && out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.idx_last   = (idx_reg == IDX_W'(TIMER_SLOTS - 1));
        stat.slot_free  = !in_use_reg[idx_reg];
        stat.pipe_busy  = s1_v_reg || s2_v_reg;
        stat.best_valid = best_v_reg;
        stat.pend_valid = pend_v_reg;
        stat.cnt_last   = (cnt_reg == CNT_W'(MAX_FIRE - 1));
        stat.out_taken  = out_v_reg && out_ready;
    end

    assign out_valid   = out_v_reg;
    assign event_kind  = out_kind_reg;
    assign status      = out_stat_reg;
    assign timer_slot  = out_slot_reg;
    assign tag_out     = out_tag_reg;
    assign last_of_run = out_last_reg;

endmodule

// ===== src/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: controller plus datapath.
//
//   channel | dir | word contents
//   req     | in  | func, now_time, period, periodic, slot_number, user_tag
//   rsp     | out | event_kind, status, timer_slot, tag_out, last_of_run
//
// An add walks the in-use bits from slot 0 up to the free one, or to the last slot when all are in use.
// A remove passes through ST_REM_READ and ST_REM_DONE, then waits in ST_OUT_END for the response handshake.
// A tick runs one full pass over the slot memory per expiry, each plus the response
// handshake, and one last pass that finds nothing due unless MAX_FIRE expiries end the
// tick; the single memory read port sets this.
// Reset clears all in-use bits at once; no word is taken while a response waits on rsp.
`timescale 1ns / 1ps

module deadline_timer_queue #(
    parameter int TIMER_SLOTS = 256,
    parameter int MAX_FIRE    = 64,
    parameter int TIME_BITS   = 48,
    parameter int TAG_BITS    = 32
) (
    input logic       clk,
    input logic       rst_n,
    dtq_in_if.sink    req,
    dtq_out_if.source rsp
);

    dtq_pkg::dtq_cmd_t    cmd;
    dtq_pkg::dtq_status_t stat;

    dtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    dtq_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .MAX_FIRE    (MAX_FIRE),
        .TIME_BITS   (TIME_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .now_time    (req.now_time),
        .period      (req.period),
        .periodic    (req.periodic),
        .slot_number (req.slot_number),
        .user_tag    (req.user_tag),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .event_kind  (rsp.event_kind),
        .status      (rsp.status),
        .timer_slot  (rsp.timer_slot),
        .tag_out     (rsp.tag_out),
        .last_of_run (rsp.last_of_run)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the deadline timer queue with a timer table scoreboard.
`timescale 1ns / 1ps

module testbench;

    localparam int          SLOTS      = 256;
    localparam int          FIRE_LIMIT = 64;
    localparam int          IDLE_LIMIT = 60000;
    localparam logic [47:0] TIME_TOP   = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  FUNC_BAD   = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [47:0] now_time;
        logic [31:0] period;
        logic        periodic;
        logic [7:0]  slot_number;
        logic [31:0] user_tag;
    } req_word_t;

    typedef struct {
        logic [1:0]  event_kind;
        logic [1:0]  status;
        logic [7:0]  timer_slot;
        logic [31:0] tag_out;
        logic        last_of_run;
    } rsp_word_t;

    class timer_table_score;
        bit          armed[SLOTS];
        logic [47:0] deadline[SLOTS];
        logic [31:0] interval[SLOTS];
        bit          repeats[SLOTS];
        logic [31:0] tag[SLOTS];
        rsp_word_t   pending_events[$];
        int          errors;

        function void push_event(logic [1:0] k, logic [1:0] st, logic [7:0] sl,
                                 logic [31:0] tg, logic lst);
            rsp_word_t r;
            r.event_kind  = k;
            r.status      = st;
            r.timer_slot  = sl;
            r.tag_out     = tg;
            r.last_of_run = lst;
            pending_events = {pending_events, r};
        endfunction

        function void note_request(req_word_t w);
            int          free_slot;
            int          fired_count;
            int          best;
            bit          fired[SLOTS];
            logic [47:0] next_due;
            free_slot = -1;
            fired_count = 0;
            case (w.func)
                dtq_pkg::FUNC_ADD:
                begin
                    for (int s = 0; s < SLOTS; s++)
                        if (!armed[s] && free_slot < 0)
                            free_slot = s;
                    if (free_slot < 0)
                        push_event(dtq_pkg::KIND_ADD, dtq_pkg::STAT_FULL, 8'd0, 32'd0, 1'b0);
                    else
                    begin
                        armed[free_slot]    = 1'b1;
                        deadline[free_slot] = w.now_time + {16'd0, w.period};
                        interval[free_slot] = w.period;
                        repeats[free_slot]  = w.periodic;
                        tag[free_slot]      = w.user_tag;
                        push_event(dtq_pkg::KIND_ADD, dtq_pkg::STAT_OK, free_slot[7:0], 32'd0,
                                   1'b0);
                    end
                end
                dtq_pkg::FUNC_REMOVE:
                begin
                    if (armed[w.slot_number])
                    begin
                        armed[w.slot_number] = 1'b0;
                        push_event(dtq_pkg::KIND_REMOVE, dtq_pkg::STAT_OK, w.slot_number,
                                   tag[w.slot_number], 1'b0);
                    end
                    else
                        push_event(dtq_pkg::KIND_REMOVE, dtq_pkg::STAT_NOTFOUND, w.slot_number,
                                   32'd0, 1'b0);
                end
                dtq_pkg::FUNC_TICK:
                begin
                    while (fired_count < FIRE_LIMIT)
                    begin
                        best = -1;
                        for (int s = 0; s < SLOTS; s++)
                            if (armed[s] && !fired[s] && deadline[s] <= w.now_time)
                                if (best < 0 || deadline[s] < deadline[best])
                                    best = s;
                        if (best < 0)
                            break;
                        fired[best] = 1'b1;
                        fired_count++;
                        push_event(dtq_pkg::KIND_EXPIRE, dtq_pkg::STAT_OK, best[7:0], tag[best],
                                   1'b0);
                        if (!repeats[best])
                            armed[best] = 1'b0;
                        else
                        begin
                            next_due = deadline[best] + {16'd0, interval[best]};
                            if (next_due <= w.now_time)
                                next_due = w.now_time + 48'd1;
                            deadline[best] = next_due;
                        end
                    end
                    if (fired_count > 0)
                        pending_events[$].last_of_run = 1'b1;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_response(rsp_word_t got);
            rsp_word_t want;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected response kind=%0d status=%0d slot=%0d tag=%h last=%0d",
                         $time, got.event_kind, got.status, got.timer_slot, got.tag_out,
                         got.last_of_run);
                errors++;
                return;
            end
            want = pending_events[0];
            pending_events.delete(0);
            if (got.event_kind !== want.event_kind || got.status !== want.status ||
                got.timer_slot !== want.timer_slot || got.tag_out !== want.tag_out ||
                got.last_of_run !== want.last_of_run)
            begin
                $display("%0t: mismatch expected kind=%0d status=%0d slot=%0d tag=%h last=%0d",
                         $time, want.event_kind, want.status, want.timer_slot, want.tag_out,
                         want.last_of_run);
                $display("%0t:          actual   kind=%0d status=%0d slot=%0d tag=%h last=%0d",
                         $time, got.event_kind, got.status, got.timer_slot, got.tag_out,
                         got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dtq_in_if #(.TIME_BITS(48)) req();
    dtq_out_if                  rsp();

    deadline_timer_queue i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    timer_table_score score;
    logic [47:0]      cur_time;
    int               burst_left;
    int               idle_cycles;
    bit               hold_rsp;
    int               ready_mode;
    int               mode_left;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        req_word_t a;
        rsp_word_t r;
        if (req.valid && req.ready)
        begin
            a.func        = req.func;
            a.now_time    = req.now_time;
            a.period      = req.period;
            a.periodic    = req.periodic;
            a.slot_number = req.slot_number;
            a.user_tag    = req.user_tag;
            score.note_request(a);
        end
        if (rsp.valid && rsp.ready)
        begin
            r.event_kind  = rsp.event_kind;
            r.status      = rsp.status;
            r.timer_slot  = rsp.timer_slot;
            r.tag_out     = rsp.tag_out;
            r.last_of_run = rsp.last_of_run;
            score.check_response(r);
        end
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("deadline_timer_queue verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        if (hold_rsp)
            rsp.ready <= 1'b0;
        else if (ready_mode == 0)
            rsp.ready <= 1'b1;
        else if (ready_mode == 1)
            rsp.ready <= ($urandom_range(0, 1) == 1);
        else
            rsp.ready <= (mode_left % 4 != 0);
    end

    task automatic hold_receiver(int cycles);
        hold_rsp = 1'b1;
        repeat (cycles) @(negedge clk);
        hold_rsp = 1'b0;
    endtask

    task automatic send_word(req_word_t w);
        if (burst_left == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        req.valid       <= 1'b1;
        req.func        <= w.func;
        req.now_time    <= w.now_time;
        req.period      <= w.period;
        req.periodic    <= w.periodic;
        req.slot_number <= w.slot_number;
        req.user_tag    <= w.user_tag;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic send(logic [1:0] f, logic [47:0] t, logic [31:0] p, logic rep,
                        logic [7:0] sn, logic [31:0] tg);
        req_word_t w;
        w.func        = f;
        w.now_time    = t;
        w.period      = p;
        w.periodic    = rep;
        w.slot_number = sn;
        w.user_tag    = tg;
        send_word(w);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (score.pending_events.size() != 0)
            @(posedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic send_random();
        int          pick;
        logic [31:0] p;
        logic [7:0]  sn;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 29) == 0)
            cur_time = 48'({$urandom(), $urandom()});
        else
            cur_time = cur_time + 48'($urandom_range(0, 20));
        p  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 60);
        sn = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 31));
        if (pick < 40)
            send(dtq_pkg::FUNC_ADD, cur_time, p, $urandom_range(0, 2) == 0, 8'($urandom()),
                 $urandom());
        else if (pick < 60)
            send(dtq_pkg::FUNC_REMOVE, 48'({$urandom(), $urandom()}), $urandom(),
                 1'($urandom()), sn, $urandom());
        else if (pick < 98)
            send(dtq_pkg::FUNC_TICK, cur_time, $urandom(), 1'($urandom()), 8'($urandom()),
                 $urandom());
        else
            send(FUNC_BAD, 48'({$urandom(), $urandom()}), $urandom(), 1'($urandom()),
                 8'($urandom()), $urandom());
    endtask

    initial
    begin
        int n_free;
        score           = new();
        cur_time        = '0;
        burst_left      = 0;
        hold_rsp        = 1'b0;
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.func        = dtq_pkg::FUNC_ADD;
        req.now_time    = '0;
        req.period      = '0;
        req.periodic    = 1'b0;
        req.slot_number = '0;
        req.user_tag    = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(dtq_pkg::FUNC_REMOVE, 48'd0, 32'd0, 1'b0, 8'd0, 32'd0);
        send(dtq_pkg::FUNC_REMOVE, TIME_TOP, 32'hFFFF_FFFF, 1'b1, 8'd255, 32'hFFFF_FFFF);
        send(dtq_pkg::FUNC_ADD, 48'd0, 32'd0, 1'b0, 8'd0, 32'hFFFF_FFFF);
        send(dtq_pkg::FUNC_ADD, 48'd0, 32'd5, 1'b1, 8'd0, 32'd0);
        send(dtq_pkg::FUNC_ADD, TIME_TOP, 32'hFFFF_FFFF, 1'b1, 8'hFF, 32'hA5A5_5A5A);
        send(dtq_pkg::FUNC_ADD, 48'd100, 32'd1, 1'b0, 8'd0, 32'h1234_5678);
        send(FUNC_BAD, TIME_TOP, 32'hFFFF_FFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF);
        send(dtq_pkg::FUNC_TICK, 48'd0, 32'd0, 1'b0, 8'd0, 32'd0);
        send(dtq_pkg::FUNC_TICK, 48'd3, 32'd0, 1'b0, 8'd0, 32'd0);
        send(dtq_pkg::FUNC_TICK, 48'd10, 32'd0, 1'b0, 8'd0, 32'd0);
        send(dtq_pkg::FUNC_REMOVE, 48'd0, 32'd0, 1'b0, 8'd1, 32'd0);
        send(dtq_pkg::FUNC_REMOVE, 48'd0, 32'd0, 1'b0, 8'd1, 32'd0);
        send(dtq_pkg::FUNC_ADD, TIME_TOP, 32'd0, 1'b1, 8'd0, 32'hC0DE_0001);
        send(dtq_pkg::FUNC_TICK, TIME_TOP, 32'd0, 1'b0, 8'd0, 32'd0);
        send(dtq_pkg::FUNC_TICK, 48'd0, 32'd0, 1'b0, 8'd0, 32'd0);
        send(dtq_pkg::FUNC_TICK, 48'd200, 32'd0, 1'b0, 8'd0, 32'd0);
        drain();

        fork
            hold_receiver(3000);
        join_none
        repeat (120) send_random();
        drain();

        n_free = 0;
        for (int s = 0; s < SLOTS; s++)
            if (!score.armed[s])
                n_free++;
        for (int s = 0; s < n_free + 3; s++)
            send(dtq_pkg::FUNC_ADD, cur_time, $urandom_range(0, 100), $urandom_range(0, 7) == 0,
                 8'($urandom()), $urandom());
        repeat (5)
            send(dtq_pkg::FUNC_TICK, TIME_TOP, $urandom(), 1'($urandom()), 8'($urandom()),
                 $urandom());
        cur_time = 48'd0;
        drain();

        repeat (120) send_random();
        drain();

        if (score.errors == 0 && score.pending_events.size() == 0)
            $display("deadline_timer_queue verification clean");
        else
            $display("deadline_timer_queue verification failed");
        $finish;
    end

endmodule
